[hw/rtl/bpm_pkg.sv]
// Package for the byte pattern masker: sizes, register indexes, shared types.
// Used by bpm_cfg, bpm_cell and byte_pattern_masker. No dependencies.
`timescale 1ns / 1ps

package bpm_pkg;

	localparam int NUM_PATTERNS      = 3;
	localparam int MAX_PATTERN_BYTES = 8;
	localparam int BYTE_W            = 8;
	localparam int PATTERN_W         = MAX_PATTERN_BYTES * BYTE_W;
	// one slot more than the longest pattern so a pass keeps taking words while it emits
	localparam int WIN_DEPTH         = MAX_PATTERN_BYTES + 1;
	localparam int IDX_W             = $clog2(WIN_DEPTH);
	localparam int FILL_W            = $clog2(WIN_DEPTH + 1);
	localparam int LEN_W             = 4;
	localparam int SUPP_W            = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;

	localparam logic [BYTE_W-1:0] MASK_CHAR = 8'h2A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE  = 3'd0,
		REG_PATTERN_FIRST  = 3'd1,
		REG_LENGTH_FIRST   = 3'd2,
		REG_PATTERN_SECOND = 3'd3,
		REG_LENGTH_SECOND  = 3'd4,
		REG_PATTERN_THIRD  = 3'd5,
		REG_LENGTH_THIRD   = 3'd6
	} cfg_reg_e;

	// per-pass settings; length is already gated by enable and saturated
	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic [LEN_W-1:0]     length;
	} pass_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} stream_word_t;

endpackage

[hw/rtl/bpm_cfg.sv]
// Configuration register file of the byte pattern masker.
// Produces the effective pattern and length of each pass. Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bpm_pkg::pass_cfg_t              pass_cfg [bpm_pkg::NUM_PATTERNS]
);

	logic                              enable_q;
	logic [bpm_pkg::PATTERN_W-1:0]     pattern_q [bpm_pkg::NUM_PATTERNS];
	logic [bpm_pkg::LEN_W-1:0]         length_q  [bpm_pkg::NUM_PATTERNS];
	logic                              wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			for (int p = 0; p < bpm_pkg::NUM_PATTERNS; p++) begin
				pattern_q[p] <= '0;
				length_q[p]  <= '0;
			end
		end else if (wr_en) begin
			case (cfg_index)
				bpm_pkg::REG_FILTER_ENABLE:  enable_q     <= cfg_data[0];
				bpm_pkg::REG_PATTERN_FIRST:  pattern_q[0] <= cfg_data[bpm_pkg::PATTERN_W-1:0];
				bpm_pkg::REG_LENGTH_FIRST:   length_q[0]  <= cfg_data[bpm_pkg::LEN_W-1:0];
				bpm_pkg::REG_PATTERN_SECOND: pattern_q[1] <= cfg_data[bpm_pkg::PATTERN_W-1:0];
				bpm_pkg::REG_LENGTH_SECOND:  length_q[1]  <= cfg_data[bpm_pkg::LEN_W-1:0];
				bpm_pkg::REG_PATTERN_THIRD:  pattern_q[2] <= cfg_data[bpm_pkg::PATTERN_W-1:0];
				bpm_pkg::REG_LENGTH_THIRD:   length_q[2]  <= cfg_data[bpm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int p = 0; p < bpm_pkg::NUM_PATTERNS; p++) begin
			pass_cfg[p].pattern = pattern_q[p];
			if (!enable_q)
				pass_cfg[p].length = '0;
			else if (length_q[p] > bpm_pkg::LEN_W'(bpm_pkg::MAX_PATTERN_BYTES))
				pass_cfg[p].length = bpm_pkg::LEN_W'(bpm_pkg::MAX_PATTERN_BYTES);
			else
				pass_cfg[p].length = length_q[p];
		end
	end

endmodule

[hw/rtl/bpm_cell.sv]
// One masking pass: a byte window, a parallel pattern compare and an output register.
// Takes words from the left, hands one word per cycle right while out_ready. Depends on bpm_pkg.
`timescale 1ns / 1ps

module bpm_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpm_pkg::pass_cfg_t    cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bpm_pkg::stream_word_t in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bpm_pkg::stream_word_t out_word
);

	localparam int FW = bpm_pkg::FILL_W;

	logic [bpm_pkg::BYTE_W-1:0]        win_q [bpm_pkg::WIN_DEPTH];
	logic [bpm_pkg::BYTE_W-1:0]        win_d [bpm_pkg::WIN_DEPTH];
	logic [FW-1:0]                     fill_q, fill_d;
	logic [bpm_pkg::SUPP_W-1:0]        supp_q, supp_d;
	logic                              flush_q, flush_d;
	logic                              pend_q, pend_d;
	logic                              out_valid_q;
	bpm_pkg::stream_word_t             out_word_q;
	bpm_pkg::stream_word_t             emit_word;

	logic [FW-1:0]                     len_f, limit_f, wr_pos;
	logic [bpm_pkg::IDX_W-1:0]         wr_idx;
	logic [bpm_pkg::MAX_PATTERN_BYTES-1:0] byte_ok;
	logic                              push, due, emit, test, hit, drain_end;

	always_comb begin
		len_f   = FW'(cfg.length);
		limit_f = (len_f != '0) ? len_f - FW'(1) : '0;

		in_ready = !flush_q && (fill_q < FW'(bpm_pkg::WIN_DEPTH));
		push     = in_valid && in_ready;

		// a pushed word owes emissions until the window is back at limit, or empty on a flush
		due  = pend_q && ((fill_q > limit_f) || (flush_q && fill_q != '0));
		emit = due && (!out_valid_q || out_ready);

		test = (len_f != '0) && (fill_q >= len_f);
		for (int k = 0; k < bpm_pkg::MAX_PATTERN_BYTES; k++)
			byte_ok[k] = (win_q[k] == cfg.pattern[k*bpm_pkg::BYTE_W +: bpm_pkg::BYTE_W])
				|| (FW'(k) >= len_f);
		hit = test && (supp_q == '0) && (&byte_ok);

		drain_end = emit && flush_q && (fill_q == FW'(1));

		emit_word.data = hit ? bpm_pkg::MASK_CHAR : win_q[0];
		emit_word.last = flush_q && (fill_q == FW'(1));

		// shift out the front byte; a hit masks the rest of the match in place
		for (int k = 0; k < bpm_pkg::WIN_DEPTH; k++)
			win_d[k] = win_q[k];
		if (emit) begin
			for (int k = 0; k < bpm_pkg::WIN_DEPTH - 1; k++)
				win_d[k] = (hit && (FW'(k + 1) < len_f)) ? bpm_pkg::MASK_CHAR : win_q[k+1];
		end
		wr_pos = fill_q - FW'(emit);
		wr_idx = wr_pos[bpm_pkg::IDX_W-1:0];
		if (push)
			win_d[wr_idx] = in_word.data;

		fill_d = fill_q - FW'(emit) + FW'(push);

		supp_d = supp_q;
		if (emit && test) begin
			if (supp_q != '0)
				supp_d = supp_q - bpm_pkg::SUPP_W'(1);
			else if (hit)
				supp_d = bpm_pkg::SUPP_W'(len_f - FW'(1));
		end
		if (((push || emit) && len_f == '0) || drain_end)
			supp_d = '0;

		flush_d = flush_q;
		if (drain_end)
			flush_d = 1'b0;
		if (push && in_word.last)
			flush_d = 1'b1;

		pend_d = push || (pend_q && ((fill_d > limit_f) || (flush_d && fill_d != '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			supp_q      <= '0;
			flush_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q  <= fill_d;
			supp_q  <= supp_d;
			flush_q <= flush_d;
			pend_q  <= pend_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
		if (emit)
			out_word_q <= emit_word;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[hw/rtl/byte_pattern_masker.sv]
// A byte passes the window and output register of each pass once the pass holds pattern
// length minus one later bytes. Throughput: one byte per cycle while the receiver is
// ready, each pass window emitting one word per cycle; a last word drains every held
// byte, and the input stalls after it until the first pass has drained.
// Reset (arst_n, async, active low): windows empty, filter enabled, all lengths zero.
`timescale 1ns / 1ps

module byte_pattern_masker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
	input  logic                           s_axis_tlast,   // in_last
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
	output logic                           m_axis_tlast,   // out_last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data
);

	bpm_pkg::pass_cfg_t    pass_cfg  [bpm_pkg::NUM_PATTERNS];
	logic                  link_valid [bpm_pkg::NUM_PATTERNS + 1];
	logic                  link_ready [bpm_pkg::NUM_PATTERNS + 1];
	bpm_pkg::stream_word_t link_word  [bpm_pkg::NUM_PATTERNS + 1];

	bpm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pass_cfg  (pass_cfg)
	);

	assign link_valid[0]     = s_axis_tvalid;
	assign s_axis_tready     = link_ready[0];
	assign link_word[0].data = s_axis_tdata;
	assign link_word[0].last = s_axis_tlast;

	for (genvar i = 0; i < bpm_pkg::NUM_PATTERNS; i++) begin : g_pass
		bpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (pass_cfg[i]),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_word   (link_word[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_word  (link_word[i+1])
		);
	end

	assign m_axis_tvalid                     = link_valid[bpm_pkg::NUM_PATTERNS];
	assign link_ready[bpm_pkg::NUM_PATTERNS] = m_axis_tready;
	assign m_axis_tdata                      = link_word[bpm_pkg::NUM_PATTERNS].data;
	assign m_axis_tlast                      = link_word[bpm_pkg::NUM_PATTERNS].last;

`ifndef ASSERT_OFF
	for (genvar i = 0; i < bpm_pkg::NUM_PATTERNS; i++) begin : g_chk
		// a pass that took a last word holds off new words while it drains
		a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
			link_valid[i] && link_ready[i] && link_word[i].last |=> !link_ready[i])
			else $error("pass %0d took a word right after a last word", i);

		// clearing the enable turns every pass into a plain wire from the next cycle
		a_disable_len: assert property (@(posedge clk) disable iff (!arst_n)
			cfg_valid && cfg_ready
			&& cfg_index == bpm_pkg::CFG_IDX_W'(bpm_pkg::REG_FILTER_ENABLE)
			&& !cfg_data[0]
			|=> pass_cfg[i].length == '0)
			else $error("pass %0d still masks after filter disable", i);
	end
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for byte_pattern_masker: directed table, then randomized frames.
// Keeps its own three-pass masking predictor; depends on bpm_pkg and the block only.
`timescale 1ns / 1ps

module tb;

	localparam int ITEMS_TARGET    = 420;
	localparam int SETTLE_CYCLES   = 24;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int CYCLE_LIMIT     = 200000;
	localparam logic [bpm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam logic [7:0] CH_A = "a";
	localparam logic [7:0] CH_B = "b";

	localparam bpm_pkg::cfg_reg_e PAT_REG [bpm_pkg::NUM_PATTERNS] =
		'{bpm_pkg::REG_PATTERN_FIRST, bpm_pkg::REG_PATTERN_SECOND, bpm_pkg::REG_PATTERN_THIRD};
	localparam bpm_pkg::cfg_reg_e LEN_REG [bpm_pkg::NUM_PATTERNS] =
		'{bpm_pkg::REG_LENGTH_FIRST, bpm_pkg::REG_LENGTH_SECOND, bpm_pkg::REG_LENGTH_THIRD};

	typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_e;

	typedef struct packed {
		row_kind_e                      kind;
		logic [bpm_pkg::CFG_IDX_W-1:0]  idx;
		logic [bpm_pkg::CFG_DATA_W-1:0] value;   // register data, or the word in 7:0
		logic                           last;
		logic                           known;
		logic [7:0]                     want_byte;
		logic                           want_last;
	} plan_row_t;

	localparam int PLAN_ROWS = 30;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// after reset every pass is a wire
		'{ROW_WORD,  REG_UNMAPPED, 64'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
		'{ROW_WRITE, REG_UNMAPPED, {bpm_pkg::CFG_DATA_W{1'b1}}, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_PATTERN_FIRST,  64'h636261, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_LENGTH_FIRST,   64'd3, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_PATTERN_SECOND, 64'h2A2A, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_LENGTH_SECOND,  64'd2, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_PATTERN_THIRD,
			{bpm_pkg::CFG_DATA_W{1'b1}}, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_LENGTH_THIRD,   64'hF, 1'b0, 1'b0, 8'h00, 1'b0},
		// "abcabc": two back to back hits in pass one, chained into pass two
		'{ROW_WORD,  REG_UNMAPPED, 64'h61, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h62, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h63, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h61, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h62, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h63, 1'b1, 1'b0, 8'h00, 1'b0},
		// eight 0xFF hit the saturated third pass
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
		// shrink pass one while it holds bytes, then disable mid-frame
		'{ROW_WORD,  REG_UNMAPPED, 64'h61, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h62, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_LENGTH_FIRST,   64'd1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h63, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_FILTER_ENABLE,  64'd0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_WORD,  REG_UNMAPPED, 64'h64, 1'b1, 1'b0, 8'h00, 1'b0},
		'{ROW_WRITE, bpm_pkg::REG_FILTER_ENABLE,  64'd1, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic s_axis_tlast = 1'b0;          // in_last
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic m_axis_tlast;                 // out_last
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	byte_pattern_masker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state: settings as written, plus held window bytes per pass
	logic                           mask_on = 1'b1;
	logic [bpm_pkg::CFG_DATA_W-1:0] pass_pat [bpm_pkg::NUM_PATTERNS] = '{default: '0};
	logic [3:0]                     pass_len [bpm_pkg::NUM_PATTERNS] = '{default: '0};
	logic [7:0]                     held [bpm_pkg::NUM_PATTERNS][bpm_pkg::MAX_PATTERN_BYTES];
	int                             held_cnt [bpm_pkg::NUM_PATTERNS] = '{default: 0};
	int                             skip_cnt [bpm_pkg::NUM_PATTERNS] = '{default: 0};

	bpm_pkg::stream_word_t pass_out[$];
	bpm_pkg::stream_word_t step_out[$];
	bpm_pkg::stream_word_t masked_q[$];

	int  errors = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  masked_out = 0;
	int  reg_writes = 0;
	int  settings_used = 1;
	int  holds_asked = 0;
	int  holds_done = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	bit  tx_up = 1'b0;
	bit  cfg_up = 1'b0;

	function automatic int live_len(input int p);
		return (pass_len[p] > bpm_pkg::MAX_PATTERN_BYTES) ? bpm_pkg::MAX_PATTERN_BYTES
			: int'(pass_len[p]);
	endfunction

	// one word into pass s; emitted words go to pass_out
	function automatic void pass_step(input int s, input bpm_pkg::stream_word_t w);
		logic [7:0] win [bpm_pkg::MAX_PATTERN_BYTES+1];
		int len, lim, f, sk, k;
		logic hit;
		bpm_pkg::stream_word_t o;
		len = mask_on ? live_len(s) : 0;
		lim = (len != 0) ? len - 1 : 0;
		f = held_cnt[s];
		for (k = 0; k < f; k++)
			win[k] = held[s][k];
		win[f] = w.data;
		f++;
		sk = skip_cnt[s];
		while (f > lim) begin
			if (len != 0 && f >= len) begin
				// starts inside the previous hit are skipped
				if (sk != 0) begin
					sk--;
				end else begin
					hit = 1'b1;
					for (k = 0; k < len; k++)
						if (win[k] != pass_pat[s][8*k +: 8])
							hit = 1'b0;
					if (hit) begin
						for (k = 0; k < len; k++)
							win[k] = bpm_pkg::MASK_CHAR;
						sk = len - 1;
					end
				end
			end
			o.data = win[0];
			o.last = 1'b0;
			pass_out = {pass_out, o};
			for (k = 0; k + 1 < f; k++)
				win[k] = win[k + 1];
			f--;
		end
		if (len == 0)
			sk = 0;
		if (w.last) begin
			// flush: whatever is held is too short to match
			for (k = 0; k < f; k++) begin
				o.data = win[k];
				o.last = 1'b0;
				pass_out = {pass_out, o};
			end
			f = 0;
			sk = 0;
			if (pass_out.size() != 0) begin
				o = pass_out.pop_back();
				o.last = 1'b1;
				pass_out = {pass_out, o};
			end
		end
		for (k = 0; k < f; k++)
			held[s][k] = win[k];
		held_cnt[s] = f;
		skip_cnt[s] = sk;
	endfunction

	function automatic void predict_masked(input logic [7:0] b, input logic l);
		bpm_pkg::stream_word_t stage_in[$];
		bpm_pkg::stream_word_t w;
		int s;
		w.data = b;
		w.last = l;
		stage_in = {stage_in, w};
		for (s = 0; s < bpm_pkg::NUM_PATTERNS; s++) begin
			pass_out.delete();
			foreach (stage_in[i])
				pass_step(s, stage_in[i]);
			stage_in = pass_out;
		end
		step_out = stage_in;
	endfunction

	function automatic void apply_reg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpm_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			bpm_pkg::REG_FILTER_ENABLE:  mask_on = val[0];
			bpm_pkg::REG_PATTERN_FIRST:  pass_pat[0] = val;
			bpm_pkg::REG_LENGTH_FIRST:   pass_len[0] = val[3:0];
			bpm_pkg::REG_PATTERN_SECOND: pass_pat[1] = val;
			bpm_pkg::REG_LENGTH_SECOND:  pass_len[1] = val[3:0];
			bpm_pkg::REG_PATTERN_THIRD:  pass_pat[2] = val;
			bpm_pkg::REG_LENGTH_THIRD:   pass_len[2] = val[3:0];
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] alpha_byte();
		case ($urandom_range(0, 5))
			0: return CH_B;
			1: return bpm_pkg::MASK_CHAR;
			2: return 8'($urandom_range(0, 255));
			default: return CH_A;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0, 1: return 8'($urandom_range(0, 255));
			2: return bpm_pkg::MASK_CHAR;
			3: return CH_A;
			4: return CH_B;
			default: return pass_pat[$urandom_range(0, bpm_pkg::NUM_PATTERNS - 1)]
				[8*$urandom_range(0, 7) +: 8];
		endcase
	endfunction

	task automatic drop_valid();
		if (tx_up) begin
			s_axis_tvalid <= 1'b0;
			tx_up = 1'b0;
		end
	endtask

	task automatic drop_cfg();
		if (cfg_up) begin
			cfg_valid <= 1'b0;
			cfg_up = 1'b0;
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic l, input logic known,
			input bpm_pkg::stream_word_t typed);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		tx_up = 1'b1;
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		words_in++;
		predict_masked(b, l);
		if (known)
			masked_q = {masked_q, typed};
		else
			foreach (step_out[i])
				masked_q = {masked_q, step_out[i]};
	endtask

	task automatic write_reg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpm_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_up = 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		reg_writes++;
		apply_reg(idx, val);
	endtask

	// sender idles until all predicted words are out, then lets the passes settle
	task automatic pause_for_idle();
		drop_valid();
		while (masked_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			drop_valid();
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	task automatic program_settings(input int mode);
		logic                           en;
		logic [bpm_pkg::CFG_DATA_W-1:0] pat [bpm_pkg::NUM_PATTERNS];
		logic [3:0]                     len [bpm_pkg::NUM_PATTERNS];
		int p, k;
		for (p = 0; p < bpm_pkg::NUM_PATTERNS; p++) begin
			for (k = 0; k < bpm_pkg::MAX_PATTERN_BYTES; k++)
				pat[p][8*k +: 8] = alpha_byte();
			case ($urandom_range(0, 7))
				0: len[p] = 4'd0;
				1: len[p] = 4'd1;
				2: len[p] = 4'd8;
				3: len[p] = 4'($urandom_range(9, 15));
				default: len[p] = 4'($urandom_range(2, 5));
			endcase
		end
		en = ($urandom_range(0, 6) != 0);
		case (mode)
			0: begin
				en = 1'b1;
				pat[0] = '1;
				len[0] = 4'd15;
				pat[1] = '0;
				len[1] = 4'd8;
				pat[2] = {bpm_pkg::MAX_PATTERN_BYTES{CH_A}};
				len[2] = 4'd1;
			end
			1: en = 1'b0;
			2: begin
				en = 1'b1;
				len = '{default: 4'd0};
			end
			default: ;
		endcase
		pause_for_idle();
		write_reg(bpm_pkg::REG_FILTER_ENABLE, {32'($urandom), 31'($urandom), en});
		for (p = 0; p < bpm_pkg::NUM_PATTERNS; p++) begin
			write_reg(PAT_REG[p], pat[p]);
			write_reg(LEN_REG[p], {32'($urandom), 28'($urandom), len[p]});
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNMAPPED, {32'($urandom), 32'($urandom)});
		drop_cfg();
		settings_used++;
	endtask

	// frame of n words, mostly pattern copies and pattern letters; cut frames carry no last
	task automatic send_frame(input int n, input logic cut);
		logic [7:0] frame[$];
		int p, k, stop;
		while (frame.size() < n) begin
			if ($urandom_range(0, 2) == 0) begin
				p = $urandom_range(0, bpm_pkg::NUM_PATTERNS - 1);
				stop = live_len(p);
				if (stop > 0 && $urandom_range(0, 3) == 0)
					stop = $urandom_range(0, stop - 1);
				for (k = 0; k < stop && frame.size() < n; k++)
					frame = {frame, pass_pat[p][8*k +: 8]};
			end else begin
				frame = {frame, pick_byte()};
			end
		end
		foreach (frame[i]) begin
			pace();
			send_word(frame[i], (i == n - 1) && !cut, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int ph);
		int budget, n;
		logic cut;
		program_settings(ph);
		if (ph % 5 == 3)
			holds_asked++;
		budget = $urandom_range(30, 60);
		while (budget > 0) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			if (n > budget)
				n = budget;
			cut = (n == budget) && ($urandom_range(0, 2) == 0);
			send_frame(n, cut);
			budget -= n;
		end
	endtask

	initial begin : stimulus
		int r, ph;
		logic prev_write;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		prev_write = 1'b0;
		for (r = 0; r < PLAN_ROWS; r++) begin
			if (PLAN[r].kind == ROW_WRITE) begin
				if (!prev_write)
					pause_for_idle();
				write_reg(PLAN[r].idx, PLAN[r].value);
				prev_write = 1'b1;
			end else begin
				drop_cfg();
				send_word(PLAN[r].value[7:0], PLAN[r].last, PLAN[r].known,
					{PLAN[r].want_byte, PLAN[r].want_last});
				prev_write = 1'b0;
			end
		end
		drop_cfg();
		ph = 0;
		while (words_in < ITEMS_TARGET) begin
			run_phase(ph);
			ph++;
		end
		pause_for_idle();
		$display("covered %0d words in, %0d words out (%0d masked), %0d register writes",
			words_in, words_out, masked_out, reg_writes);
		$display("over %0d settings with %0d long receiver hold-offs", settings_used, holds_done);
		if (errors == 0)
			$display("byte_pattern_masker: match");
		else
			$display("byte_pattern_masker: mismatch");
		$finish;
	end

	// receiver: changing stall patterns, plus a long hold-off on request
	initial begin : rx_side
		int mode, run, n;
		mode = 0;
		run = 0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				m_axis_tready <= 1'b0;
				for (n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
				holds_done++;
			end
			if (run == 0) begin
				mode = $urandom_range(0, 3);
				run = $urandom_range(16, 80);
			end
			run--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (run % 3 == 0);
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// capture at the edge, compare after the sender has booked that edge's predictions
	initial begin : rx_check
		bpm_pkg::stream_word_t got, want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
				got.data = m_axis_tdata;
				got.last = m_axis_tlast;
				@(negedge clk);
				words_out++;
				if (got.data == bpm_pkg::MASK_CHAR)
					masked_out++;
				if (masked_q.size() == 0) begin
					$error("out_byte: no word expected, got %02h (out_last %b)",
						got.data, got.last);
					errors++;
				end else begin
					want = masked_q.pop_front();
					if (got.data !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, got.data);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, got.last);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("byte_pattern_masker: mismatch");
			$finish;
		end
	end

endmodule

[byte_pattern_masker.f]
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_cfg.sv
hw/rtl/bpm_cell.sv
hw/rtl/byte_pattern_masker.sv
tb/tb.sv
